@@ hw/rtl/pocc_pkg.sv @@
// ----------------------------------------------------------------------------
// pocc_pkg
// Shared types and constants for the point and obstacle collision check.
// ----------------------------------------------------------------------------
package pocc_pkg;

  // defaults for the top level parameters
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int SLOT_BITS = 4;
  localparam int SIZE_BITS = 15;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // obstacle kinds
  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_RECT   = 2'd2,
    KIND_CIRCLE = 2'd3
  } kind_t;

  // control part of an item travelling down the chain
  typedef struct packed {
    logic                 valid;
    logic                 mode;
    logic [SLOT_BITS-1:0] slot;
    kind_t                kind;
    logic                 blocking;
    logic                 hit;
  } item_ctrl_t;

  // size fields of an item
  typedef struct packed {
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    logic [SIZE_BITS-1:0] r;
  } sizes_t;

endpackage

@@ hw/rtl/pocc_in_if.sv @@
// ----------------------------------------------------------------------------
// pocc_in_if
// Item channel into the collision check: slot writes and point queries.
// ----------------------------------------------------------------------------
interface pocc_in_if #(
  parameter int COORD_BITS = pocc_pkg::COORD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [pocc_pkg::SLOT_BITS-1:0]     slot;
  logic [1:0]                         kind;
  logic                               blocking;
  logic signed [COORD_BITS-1:0]       pos_x;
  logic signed [COORD_BITS-1:0]       pos_y;
  logic [pocc_pkg::SIZE_BITS-1:0]     size_w;
  logic [pocc_pkg::SIZE_BITS-1:0]     size_h;
  logic [pocc_pkg::SIZE_BITS-1:0]     radius;

  modport source (
    output valid, mode, slot, kind, blocking, pos_x, pos_y, size_w, size_h, radius,
    input  ready
  );

  modport sink (
    input  valid, mode, slot, kind, blocking, pos_x, pos_y, size_w, size_h, radius,
    output ready
  );
endinterface

@@ hw/rtl/pocc_out_if.sv @@
// ----------------------------------------------------------------------------
// pocc_out_if
// Result channel out of the collision check.
// ----------------------------------------------------------------------------
interface pocc_out_if;
  logic valid;
  logic ready;
  logic touching;

  modport source (
    output valid, touching,
    input  ready
  );

  modport sink (
    input  valid, touching,
    output ready
  );
endinterface

@@ hw/rtl/pocc_cell.sv @@
// ----------------------------------------------------------------------------
// pocc_cell
// One obstacle slot of the chain: holds the slot, applies writes addressed
// to it and tests passing queries against it over four pipeline stages.
// ----------------------------------------------------------------------------
module pocc_cell #(
  parameter int COORD_BITS = pocc_pkg::COORD_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  pocc_pkg::item_ctrl_t         i_ctrl,
  input  logic signed [COORD_BITS-1:0] i_x,
  input  logic signed [COORD_BITS-1:0] i_y,
  input  pocc_pkg::sizes_t             i_sz,
  output pocc_pkg::item_ctrl_t         o_ctrl,
  output logic signed [COORD_BITS-1:0] o_x,
  output logic signed [COORD_BITS-1:0] o_y,
  output pocc_pkg::sizes_t             o_sz
);

  localparam int SZ  = pocc_pkg::SIZE_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int MW  = (DW > SZ) ? DW : SZ;
  localparam int RW  = (DW + 1 > SZ) ? DW + 1 : SZ;
  localparam int SQW = 2 * SZ;

  // slot contents
  pocc_pkg::kind_t              kind_r;
  logic                         blk_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [SZ-1:0]                w_r, h_r, rad_r;

  // stage registers
  pocc_pkg::item_ctrl_t         s1_ctrl_r, s2_ctrl_r, s3_ctrl_r, o_ctrl_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s2_x_r, s3_x_r, o_x_r;
  logic signed [COORD_BITS-1:0] s1_y_r, s2_y_r, s3_y_r, o_y_r;
  pocc_pkg::sizes_t             s1_sz_r, s2_sz_r, s3_sz_r, o_sz_r;

  logic                         s1_pt_r, s1_rect_r, s1_circ_r;
  logic signed [DW-1:0]         s1_dx_r, s1_dy_r;
  logic [SZ-1:0]                s1_w_r, s1_h_r, s1_r_r;

  logic                         s2_part_r, s2_circ_r;
  logic [SZ-1:0]                s2_ax_r, s2_ay_r, s2_r_r;

  logic                         s3_part_r, s3_circ_r;
  logic [SQW-1:0]               s3_sqx_r, s3_sqy_r, s3_sqr_r;

  // combinational values
  logic                         slot_match, query;
  logic signed [DW-1:0]         dx_nxt, dy_nxt;
  logic [DW-1:0]                ax, ay;
  logic [MW-1:0]                ax_m, ay_m;
  logic                         rect_ok, pt_ok, range_ok;
  logic                         part_nxt, circ_go_nxt, circ_ok;
  pocc_pkg::item_ctrl_t         o_ctrl_nxt;

  // write decode and query qualification
  assign slot_match = i_ctrl.valid && (i_ctrl.mode == pocc_pkg::MODE_WRITE) &&
                      (int'(i_ctrl.slot) == IDX);
  assign query      = i_ctrl.valid && (i_ctrl.mode == pocc_pkg::MODE_QUERY);

  // stage 1: signed offsets from the slot centre
  assign dx_nxt = DW'(i_x) - DW'(cx_r);
  assign dy_nxt = DW'(i_y) - DW'(cy_r);

  // stage 2: magnitudes and the cheap tests
  assign ax       = s1_dx_r[DW-1] ? DW'(-s1_dx_r) : DW'(s1_dx_r);
  assign ay       = s1_dy_r[DW-1] ? DW'(-s1_dy_r) : DW'(s1_dy_r);
  assign ax_m     = MW'(ax);
  assign ay_m     = MW'(ay);
  assign rect_ok  = (RW'({ax, 1'b0}) <= RW'(s1_w_r)) && (RW'({ay, 1'b0}) <= RW'(s1_h_r));
  assign pt_ok    = (ax == '0) && (ay == '0);
  assign range_ok = (ax_m <= MW'(s1_r_r)) && (ay_m <= MW'(s1_r_r));
  assign part_nxt    = (s1_rect_r && rect_ok) || (s1_pt_r && pt_ok);
  assign circ_go_nxt = s1_circ_r && range_ok;

  // stage 4: distance against radius, merged into the running hit flag
  assign circ_ok = s3_circ_r &&
                   ((SQW + 1)'(s3_sqx_r) + (SQW + 1)'(s3_sqy_r) <= (SQW + 1)'(s3_sqr_r));

  always_comb begin
    o_ctrl_nxt     = s3_ctrl_r;
    o_ctrl_nxt.hit = s3_ctrl_r.hit || s3_part_r || circ_ok;
  end

  // control registers and slot kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= pocc_pkg::KIND_EMPTY;
      blk_r     <= 1'b0;
      s1_ctrl_r <= '0;
      s2_ctrl_r <= '0;
      s3_ctrl_r <= '0;
      o_ctrl_r  <= '0;
    end else if (en) begin
      if (slot_match) begin
        kind_r <= i_ctrl.kind;
        blk_r  <= i_ctrl.blocking;
      end
      s1_ctrl_r <= i_ctrl;
      s2_ctrl_r <= s1_ctrl_r;
      s3_ctrl_r <= s2_ctrl_r;
      o_ctrl_r  <= o_ctrl_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      if (slot_match) begin
        cx_r  <= i_x;
        cy_r  <= i_y;
        w_r   <= i_sz.w;
        h_r   <= i_sz.h;
        rad_r <= i_sz.r;
      end
      // item payload
      s1_x_r  <= i_x;    s2_x_r  <= s1_x_r;  s3_x_r  <= s2_x_r;  o_x_r  <= s3_x_r;
      s1_y_r  <= i_y;    s2_y_r  <= s1_y_r;  s3_y_r  <= s2_y_r;  o_y_r  <= s3_y_r;
      s1_sz_r <= i_sz;   s2_sz_r <= s1_sz_r; s3_sz_r <= s2_sz_r; o_sz_r <= s3_sz_r;
      // stage 1 snapshot of the slot
      s1_pt_r   <= query && blk_r && (kind_r == pocc_pkg::KIND_POINT);
      s1_rect_r <= query && blk_r && (kind_r == pocc_pkg::KIND_RECT);
      s1_circ_r <= query && blk_r && (kind_r == pocc_pkg::KIND_CIRCLE);
      s1_dx_r   <= dx_nxt;
      s1_dy_r   <= dy_nxt;
      s1_w_r    <= w_r;
      s1_h_r    <= h_r;
      s1_r_r    <= rad_r;
      // stage 2
      s2_part_r <= part_nxt;
      s2_circ_r <= circ_go_nxt;
      s2_ax_r   <= ax_m[SZ-1:0];
      s2_ay_r   <= ay_m[SZ-1:0];
      s2_r_r    <= s1_r_r;
      // stage 3 squares
      s3_part_r <= s2_part_r;
      s3_circ_r <= s2_circ_r;
      s3_sqx_r  <= SQW'(s2_ax_r) * SQW'(s2_ax_r);
      s3_sqy_r  <= SQW'(s2_ay_r) * SQW'(s2_ay_r);
      s3_sqr_r  <= SQW'(s2_r_r) * SQW'(s2_r_r);
    end
  end

  assign o_ctrl = o_ctrl_r;
  assign o_x    = o_x_r;
  assign o_y    = o_y_r;
  assign o_sz   = o_sz_r;

  // a write item never picks up a hit
  a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    o_ctrl_r.valid && (o_ctrl_r.mode == pocc_pkg::MODE_WRITE) |-> !o_ctrl_r.hit)
    else $error("write transfer leaves cell with hit set");

  // a hit found upstream survives this cell
  a_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    en && s3_ctrl_r.valid && s3_ctrl_r.hit |=> o_ctrl_r.hit)
    else $error("hit flag lost in cell");

  // an addressed write loads kind and blocking
  a_slot_write: assert property (@(posedge clk) disable iff (!rst_n)
    en && slot_match |=> (kind_r == $past(i_ctrl.kind)) && (blk_r == $past(i_ctrl.blocking)))
    else $error("slot write not applied");

  // a stalled chain holds its output stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(o_ctrl_r))
    else $error("cell output changed during stall");

endmodule

@@ hw/rtl/point_obstacle_collision_check.sv @@
// ----------------------------------------------------------------------------
// point_obstacle_collision_check
// Chain of obstacle slot cells testing query points against every slot.
// ----------------------------------------------------------------------------
// Every item (slot write or point query) walks through a chain of NUM_SLOTS
// cells, one cell per obstacle slot, and its result leaves the last cell.
// Items follow one another through the chain in order, one accepted per
// cycle while the result side keeps taking transfers; a write updates its
// addressed slot as it passes, so any later query sees it. The whole chain
// advances together: when a result waits at the end and out_ch.ready is low,
// in_ch.ready drops until it moves. Writes return touching = 0; writes to a
// slot at or beyond NUM_SLOTS are dropped.
module point_obstacle_collision_check #(
  parameter int NUM_SLOTS  = pocc_pkg::NUM_SLOTS_DEF,
  parameter int COORD_BITS = pocc_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pocc_in_if.sink       in_ch,
  pocc_out_if.source    out_ch
);

  pocc_pkg::item_ctrl_t         ctrl_a [NUM_SLOTS+1];
  logic signed [COORD_BITS-1:0] x_a    [NUM_SLOTS+1];
  logic signed [COORD_BITS-1:0] y_a    [NUM_SLOTS+1];
  pocc_pkg::sizes_t             sz_a   [NUM_SLOTS+1];
  logic                         en;

  // chain advances unless a result is held at the end
  assign en          = !ctrl_a[NUM_SLOTS].valid || out_ch.ready;
  assign in_ch.ready = en;

  // item entering the chain
  always_comb begin
    ctrl_a[0].valid    = in_ch.valid;
    ctrl_a[0].mode     = in_ch.mode;
    ctrl_a[0].slot     = in_ch.slot;
    ctrl_a[0].kind     = pocc_pkg::kind_t'(in_ch.kind);
    ctrl_a[0].blocking = in_ch.blocking;
    ctrl_a[0].hit      = 1'b0;
    x_a[0]             = in_ch.pos_x;
    y_a[0]             = in_ch.pos_y;
    sz_a[0].w          = in_ch.size_w;
    sz_a[0].h          = in_ch.size_h;
    sz_a[0].r          = in_ch.radius;
  end

  // one cell per obstacle slot
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pocc_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX        (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .i_ctrl (ctrl_a[g]),
      .i_x    (x_a[g]),
      .i_y    (y_a[g]),
      .i_sz   (sz_a[g]),
      .o_ctrl (ctrl_a[g+1]),
      .o_x    (x_a[g+1]),
      .o_y    (y_a[g+1]),
      .o_sz   (sz_a[g+1])
    );
  end

  // result transfer
  assign out_ch.valid    = ctrl_a[NUM_SLOTS].valid;
  assign out_ch.touching = ctrl_a[NUM_SLOTS].hit;

endmodule

@@ tb/sv/pocc_touch_checker.sv @@
// ----------------------------------------------------------------------------
// pocc_touch_checker
// Watches both channels of the collision check, keeps its own copy of the
// obstacle table, predicts the touching flag of every accepted item and
// compares it with each result transfer, oldest first.
// ----------------------------------------------------------------------------
module pocc_touch_checker #(
  parameter int NUM_SLOTS  = pocc_pkg::NUM_SLOTS_DEF,
  parameter int COORD_BITS = pocc_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pocc_in_if   in_ch,
  pocc_out_if  out_ch,
  output int   fail_cnt,
  output int   pending_cnt
);

  // shadow obstacle table
  pocc_pkg::kind_t      obs_kind   [NUM_SLOTS];
  logic                 obs_block  [NUM_SLOTS];
  longint               obs_cx     [NUM_SLOTS];
  longint               obs_cy     [NUM_SLOTS];
  longint               obs_w      [NUM_SLOTS];
  longint               obs_h      [NUM_SLOTS];
  longint               obs_r      [NUM_SLOTS];

  // touching flags still owed by the block, oldest first
  logic                 touch_due[$];

  // does the point hit any blocking obstacle
  function automatic logic point_touches(longint qx, longint qy);
    longint ax;
    longint ay;
    logic   hit;
    int     s;
    hit = 1'b0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (obs_block[s]) begin
        ax = qx - obs_cx[s];
        ay = qy - obs_cy[s];
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        case (obs_kind[s])
          pocc_pkg::KIND_CIRCLE: begin
            if (ax <= obs_r[s] && ay <= obs_r[s] && ax * ax + ay * ay <= obs_r[s] * obs_r[s])
              hit = 1'b1;
          end
          pocc_pkg::KIND_RECT: begin
            if (2 * ax <= obs_w[s] && 2 * ay <= obs_h[s]) hit = 1'b1;
          end
          pocc_pkg::KIND_POINT: begin
            if (ax == 0 && ay == 0) hit = 1'b1;
          end
          default: ;
        endcase
      end
    end
    return hit;
  endfunction

  // compare result transfers, then predict for the accepted item
  always @(posedge clk) begin
    logic due;
    int   s;
    if (!rst_n) begin
      for (s = 0; s < NUM_SLOTS; s++) begin
        obs_kind[s]  = pocc_pkg::KIND_EMPTY;
        obs_block[s] = 1'b0;
        obs_cx[s]    = 0;
        obs_cy[s]    = 0;
        obs_w[s]     = 0;
        obs_h[s]     = 0;
        obs_r[s]     = 0;
      end
      touch_due.delete();
      fail_cnt    <= 0;
      pending_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (touch_due.size() == 0) begin
          $error("touching: result transfer with nothing outstanding, actual %0b",
                 out_ch.touching);
          fail_cnt <= fail_cnt + 1;
        end else begin
          due = touch_due.pop_front();
          if (out_ch.touching !== due) begin
            $error("touching: expected %0b, actual %0b", due, out_ch.touching);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == pocc_pkg::MODE_WRITE) begin
          // writes store every field and answer with no touch
          if (int'(in_ch.slot) < NUM_SLOTS) begin
            obs_kind[in_ch.slot]  = pocc_pkg::kind_t'(in_ch.kind);
            obs_block[in_ch.slot] = in_ch.blocking;
            obs_cx[in_ch.slot]    = longint'(in_ch.pos_x);
            obs_cy[in_ch.slot]    = longint'(in_ch.pos_y);
            obs_w[in_ch.slot]     = longint'(in_ch.size_w);
            obs_h[in_ch.slot]     = longint'(in_ch.size_h);
            obs_r[in_ch.slot]     = longint'(in_ch.radius);
          end
          touch_due = {touch_due, 1'b0};
        end else begin
          touch_due = {touch_due,
                       point_touches(longint'(in_ch.pos_x), longint'(in_ch.pos_y))};
        end
      end
      pending_cnt <= touch_due.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the point and obstacle collision check: a directed
// run over extreme and boundary obstacles, then random slot writes and
// queries mostly aimed at known obstacles, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_SLOTS   = pocc_pkg::NUM_SLOTS_DEF;
  localparam int COORD_BITS  = pocc_pkg::COORD_BITS_DEF;
  localparam int SLOT_BITS   = pocc_pkg::SLOT_BITS;
  localparam int SIZE_BITS   = pocc_pkg::SIZE_BITS;
  localparam int RAND_ITEMS  = 2000;
  localparam int IDLE_LIMIT  = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 4 * NUM_SLOTS + 16;

  typedef struct {
    logic                         mode;
    logic [SLOT_BITS-1:0]         slot;
    pocc_pkg::kind_t              kind;
    logic                         blocking;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]         w;
    logic [SIZE_BITS-1:0]         h;
    logic [SIZE_BITS-1:0]         r;
  } obstacle_item_t;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending_cnt;
  logic sender_burst;
  logic receiver_burst;

  // where random queries are aimed, per slot
  int   aim_x     [NUM_SLOTS];
  int   aim_y     [NUM_SLOTS];
  int   aim_reach [NUM_SLOTS];

  pocc_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  pocc_out_if                           out_ch ();

  point_obstacle_collision_check #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pocc_touch_checker #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic obstacle_item_t slot_write(int slot, pocc_pkg::kind_t kind,
                                                logic blocking,
                                                int x, int y, int w, int h, int r);
    obstacle_item_t it;
    it.mode     = pocc_pkg::MODE_WRITE;
    it.slot     = SLOT_BITS'(slot);
    it.kind     = kind;
    it.blocking = blocking;
    it.x        = COORD_BITS'(x);
    it.y        = COORD_BITS'(y);
    it.w        = SIZE_BITS'(w);
    it.h        = SIZE_BITS'(h);
    it.r        = SIZE_BITS'(r);
    return it;
  endfunction

  function automatic obstacle_item_t point_query(int x, int y);
    obstacle_item_t it;
    // fields a query ignores still carry random bits
    it.mode     = pocc_pkg::MODE_QUERY;
    it.slot     = SLOT_BITS'($urandom);
    it.kind     = pocc_pkg::kind_t'($urandom_range(0, 3));
    it.blocking = 1'($urandom);
    it.x        = COORD_BITS'(x);
    it.y        = COORD_BITS'(y);
    it.w        = SIZE_BITS'($urandom);
    it.h        = SIZE_BITS'($urandom);
    it.r        = SIZE_BITS'($urandom);
    return it;
  endfunction

  // random write or query, queries mostly near a written obstacle
  function automatic obstacle_item_t random_item();
    obstacle_item_t it;
    int             s;
    int             reach;
    int             big;
    if ($urandom_range(0, 99) < 30) begin
      it.mode     = pocc_pkg::MODE_WRITE;
      it.slot     = SLOT_BITS'($urandom);
      it.kind     = pocc_pkg::kind_t'($urandom_range(0, 3));
      it.blocking = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 1) == 1) begin
        it.x = COORD_BITS'($urandom);
        it.y = COORD_BITS'($urandom);
      end else begin
        it.x = COORD_BITS'(int'($urandom_range(0, 4095)) - 2048);
        it.y = COORD_BITS'(int'($urandom_range(0, 4095)) - 2048);
      end
      big  = ($urandom_range(0, 4) == 0);
      it.w = big ? SIZE_BITS'($urandom) : SIZE_BITS'($urandom_range(0, 511));
      it.h = big ? SIZE_BITS'($urandom) : SIZE_BITS'($urandom_range(0, 511));
      it.r = big ? SIZE_BITS'($urandom) : SIZE_BITS'($urandom_range(0, 511));
      s = int'(it.slot);
      aim_x[s] = int'(it.x);
      aim_y[s] = int'(it.y);
      if (it.kind == pocc_pkg::KIND_CIRCLE) aim_reach[s] = int'(it.r) + 2;
      else aim_reach[s] = ((it.w > it.h) ? int'(it.w) : int'(it.h)) / 2 + 2;
    end else if ($urandom_range(0, 3) != 0) begin
      s     = $urandom_range(0, NUM_SLOTS - 1);
      reach = aim_reach[s];
      if ($urandom_range(0, 9) == 0)
        it = point_query(aim_x[s], aim_y[s]);
      else
        it = point_query(aim_x[s] + int'($urandom_range(0, 2 * reach)) - reach,
                         aim_y[s] + int'($urandom_range(0, 2 * reach)) - reach);
    end else begin
      it = point_query(int'($urandom), int'($urandom));
    end
    return it;
  endfunction

  // offer one item and wait for its transfer
  task automatic send(input obstacle_item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= it.mode;
    in_ch.slot     <= it.slot;
    in_ch.kind     <= it.kind;
    in_ch.blocking <= it.blocking;
    in_ch.pos_x    <= it.x;
    in_ch.pos_y    <= it.y;
    in_ch.size_w   <= it.w;
    in_ch.size_h   <= it.h;
    in_ch.radius   <= it.r;
    do @(posedge clk); while (!in_ch.ready);
    gap = sender_burst ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // stimulus
  initial begin
    int i;
    rst_n          = 1'b0;
    sender_burst   = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = pocc_pkg::MODE_WRITE;
    in_ch.slot     = '0;
    in_ch.kind     = pocc_pkg::KIND_EMPTY;
    in_ch.blocking = 1'b0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.size_w   = '0;
    in_ch.size_h   = '0;
    in_ch.radius   = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      aim_x[i]     = 0;
      aim_y[i]     = 0;
      aim_reach[i] = 2;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table after reset
    send(point_query(0, 0));
    // point at the coordinate extremes, unused fields all ones
    send(slot_write(0, pocc_pkg::KIND_POINT, 1'b1, 32767, -32768, 32767, 32767, 32767));
    send(point_query(32767, -32768));
    send(point_query(32767, -32767));
    // widest flat rectangle, bounds inclusive
    send(slot_write(15, pocc_pkg::KIND_RECT, 1'b1, 0, 0, 32767, 0, 0));
    send(point_query(16383, 0));
    send(point_query(16384, 0));
    send(point_query(-16383, 0));
    send(point_query(0, 1));
    // largest circle in a corner, distances past the coordinate range
    send(slot_write(7, pocc_pkg::KIND_CIRCLE, 1'b1, -32768, -32768, 0, 0, 32767));
    send(point_query(-1, -32768));
    send(point_query(-1, -1));
    send(point_query(32767, 32767));
    // small circle, exactly on and just past the rim
    send(slot_write(3, pocc_pkg::KIND_CIRCLE, 1'b1, 100, 200, 0, 0, 5));
    send(point_query(103, 204));
    send(point_query(103, 205));
    send(point_query(95, 200));
    // non-blocking circle and blocking empty slot never hit
    send(slot_write(4, pocc_pkg::KIND_CIRCLE, 1'b0, 1000, 1000, 0, 0, 100));
    send(point_query(1000, 1000));
    send(slot_write(5, pocc_pkg::KIND_EMPTY, 1'b1, 2000, 2000, 500, 500, 500));
    send(point_query(2000, 2000));
    // clearing the point slot
    send(slot_write(0, pocc_pkg::KIND_EMPTY, 1'b1, 32767, -32768, 0, 0, 0));
    send(point_query(32767, -32768));
    // zero-size rectangle hit only at its centre
    send(slot_write(6, pocc_pkg::KIND_RECT, 1'b1, -32768, 32767, 0, 0, 0));
    send(point_query(-32768, 32767));

    // random part
    for (i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 49) == 0) sender_burst = !sender_burst;
      send(random_item());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain and let the chain settle
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls plus two long hold-offs
  initial begin
    int stall;
    int hold;
    int got;
    stall          = 0;
    hold           = 0;
    got            = 0;
    receiver_burst = 1'b0;
    out_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got++;
        if (got == 400 || got == 1400) hold = LONG_HOLD;
        if ($urandom_range(0, 49) == 0) receiver_burst = !receiver_burst;
        stall = receiver_burst ? 0 : $urandom_range(0, 16);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pocc_pkg.sv
hw/rtl/pocc_in_if.sv
hw/rtl/pocc_out_if.sv
hw/rtl/pocc_cell.sv
hw/rtl/point_obstacle_collision_check.sv
tb/sv/pocc_touch_checker.sv
tb/sv/tb.sv
